[hw/rtl/mwsm_pkg.sv]
// Package for the mecanum wheel speed mixer: widths, register indexes,
// reset values, command clamp and the bundles passed between the parts.
// No dependencies.
`default_nettype none

package mwsm_pkg;

  localparam int unsigned RatioFracBits = 16;
  localparam int unsigned RatioWidth    = 24;
  localparam int unsigned LimitWidth    = 15;
  localparam int unsigned SpeedWidth    = 16;
  localparam int unsigned SumWidth      = 18;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CfgDataWidth  = 24;
  localparam int unsigned NumWheels     = 4;
  localparam int unsigned DivSteps      = 15;
  localparam int unsigned DividendWidth = 31;

  localparam logic [CfgIdxWidth-1:0] CfgXLimit      = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgYLimit      = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgZLimit      = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgRotateRatio = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgRpmRatio    = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgMaxRpm      = 3'd5;

  localparam logic [LimitWidth-1:0] XLimitReset      = 15'd3000;
  localparam logic [LimitWidth-1:0] YLimitReset      = 15'd3000;
  localparam logic [LimitWidth-1:0] ZLimitReset      = 15'd3000;
  localparam logic [RatioWidth-1:0] RotateRatioReset = 24'd327680;
  localparam logic [RatioWidth-1:0] RpmRatioReset    = 24'd131072;
  localparam logic [LimitWidth-1:0] MaxRpmReset      = 15'd8500;

  typedef struct packed {
    logic [LimitWidth-1:0] x_limit;
    logic [LimitWidth-1:0] y_limit;
    logic [LimitWidth-1:0] z_limit;
    logic [RatioWidth-1:0] rotate_ratio;
    logic [RatioWidth-1:0] rpm_ratio;
    logic [LimitWidth-1:0] max_rpm;
  } cfg_t;

  // wheel sums before the rpm multiply, order RF, LF, LR, RR
  typedef struct packed {
    logic [NumWheels-1:0][SumWidth-1:0] sum;
  } sums_t;

  typedef struct packed {
    logic                                    scale;
    logic [SpeedWidth-1:0]                   divisor;
    logic [NumWheels-1:0][DividendWidth-1:0] dividend;
    logic [NumWheels-1:0][SpeedWidth-1:0]    wheel;
  } div_in_t;

  function automatic logic [SpeedWidth-1:0] clamp_cmd(logic [SpeedWidth-1:0] v,
                                                       logic [LimitWidth-1:0] lim);
    logic signed [SpeedWidth:0] vs;
    logic signed [SpeedWidth:0] hi;
    logic signed [SpeedWidth:0] lo;
    logic signed [SpeedWidth:0] r;
    vs = $signed({v[SpeedWidth-1], v});
    hi = $signed({2'b00, lim});
    lo = -hi;
    if (vs > hi) r = hi;
    else if (vs < lo) r = lo;
    else r = vs;
    return r[SpeedWidth-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mwsm_front.sv]
// Front part: takes command beats, clamps them, forms the saturated
// rotation term and the four wheel sums. Depends on mwsm_pkg.
`default_nettype none

module mwsm_front #(
  parameter int unsigned RATIO_FRAC_BITS = mwsm_pkg::RatioFracBits
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  mwsm_pkg::cfg_t                   cfg_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire [mwsm_pkg::SpeedWidth-1:0]   speed_x_i,
  input  wire [mwsm_pkg::SpeedWidth-1:0]   speed_y_i,
  input  wire [mwsm_pkg::SpeedWidth-1:0]   speed_turn_i,
  output logic                             push_o,
  input  wire                              full_i,
  output mwsm_pkg::sums_t                  entry_o
);

  localparam int unsigned TProdWidth = mwsm_pkg::LimitWidth + mwsm_pkg::RatioWidth;
  localparam int unsigned SW = mwsm_pkg::SpeedWidth;
  localparam int unsigned SumW = mwsm_pkg::SumWidth;

  logic          v0_q, v1_q;
  logic          en0, en1;
  logic [SW-1:0] vx0_q, vy0_q, vw0_q;
  logic [SW-1:0] vx1_q, vy1_q;
  logic          tneg_q;
  logic [TProdWidth-1:0] tprod_q;

  logic [SW-1:0]         vw_abs;
  logic [TProdWidth-1:0] tsh;
  logic [SW-1:0]         tmag;
  logic signed [SumW-1:0] x18, y18, t18;

  assign en1        = !v1_q || !full_i;
  assign en0        = !v0_q || en1;
  assign in_ready_o = en0;
  assign push_o     = v1_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
    end
  end

  assign vw_abs = vw0_q[SW-1] ? SW'(-vw0_q) : vw0_q;

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      vx0_q <= mwsm_pkg::clamp_cmd(speed_x_i, cfg_i.x_limit);
      vy0_q <= mwsm_pkg::clamp_cmd(speed_y_i, cfg_i.y_limit);
      vw0_q <= mwsm_pkg::clamp_cmd(speed_turn_i, cfg_i.z_limit);
    end
    if (en1 && v0_q) begin
      vx1_q   <= vx0_q;
      vy1_q   <= vy0_q;
      tneg_q  <= vw0_q[SW-1];
      // clamped magnitude never exceeds 32767
      tprod_q <= TProdWidth'(vw_abs[mwsm_pkg::LimitWidth-1:0]) *
                 TProdWidth'(cfg_i.rotate_ratio);
    end
  end

  // truncate toward zero, saturate to the 16 bit range
  always_comb begin
    tsh = tprod_q >> RATIO_FRAC_BITS;
    if (tneg_q) begin
      tmag = (tsh > TProdWidth'(32768)) ? 16'h8000 : tsh[SW-1:0];
    end else begin
      tmag = (tsh > TProdWidth'(32767)) ? 16'h7fff : tsh[SW-1:0];
    end
    t18 = tneg_q ? -$signed({2'b00, tmag}) : $signed({2'b00, tmag});
    x18 = $signed({{2{vx1_q[SW-1]}}, vx1_q});
    y18 = $signed({{2{vy1_q[SW-1]}}, vy1_q});
    entry_o.sum[0] = SumW'(-x18 + y18 + t18);
    entry_o.sum[1] = SumW'(-x18 - y18 + t18);
    entry_o.sum[2] = SumW'(x18 - y18 + t18);
    entry_o.sum[3] = SumW'(x18 + y18 + t18);
  end

endmodule

`default_nettype wire

[hw/rtl/mwsm_queue.sv]
// Two-entry queue of wheel sums between the front and back parts.
// Depends on mwsm_pkg.
`default_nettype none

module mwsm_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  mwsm_pkg::sums_t  data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             valid_o,
  output mwsm_pkg::sums_t  data_o
);

  mwsm_pkg::sums_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;
  logic       do_pop;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      unique case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

[hw/rtl/mwsm_back.sv]
// Back part: rpm multiply with saturation, largest wheel magnitude and the
// rescale dividend. Feeds the divider. Depends on mwsm_pkg.
`default_nettype none

module mwsm_back #(
  parameter int unsigned RATIO_FRAC_BITS = mwsm_pkg::RatioFracBits
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  mwsm_pkg::cfg_t     cfg_i,
  input  wire                en_i,
  input  wire                valid_i,
  input  mwsm_pkg::sums_t    data_i,
  output logic               valid_o,
  output mwsm_pkg::div_in_t  div_o
);

  localparam int unsigned NW    = mwsm_pkg::NumWheels;
  localparam int unsigned SW    = mwsm_pkg::SpeedWidth;
  localparam int unsigned SumW  = mwsm_pkg::SumWidth;
  localparam int unsigned PW    = SumW - 1 + mwsm_pkg::RatioWidth;
  localparam int unsigned DW    = mwsm_pkg::DividendWidth;

  logic v0_q, v1_q, v2_q;

  logic [NW-1:0]         neg0_q;
  logic [NW-1:0][PW-1:0] prod0_q;
  logic [NW-1:0][SW-1:0] mag1_q, wheel1_q;
  logic [SW-1:0]         largest1_q;
  logic                  scale1_q;

  logic [NW-1:0][SumW-1:0] sabs;
  logic [NW-1:0][PW-1:0]   psh;
  logic [NW-1:0][SW-1:0]   mag, wheel;
  logic [SW-1:0]           max01, max23, largest;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      sabs[i] = data_i.sum[i][SumW-1] ? SumW'(-data_i.sum[i]) : data_i.sum[i];
      psh[i]  = prod0_q[i] >> RATIO_FRAC_BITS;
      if (neg0_q[i]) begin
        mag[i] = (psh[i] > PW'(32768)) ? 16'h8000 : psh[i][SW-1:0];
      end else begin
        mag[i] = (psh[i] > PW'(32767)) ? 16'h7fff : psh[i][SW-1:0];
      end
      wheel[i] = neg0_q[i] ? SW'(-mag[i]) : mag[i];
    end
    max01   = (mag[0] > mag[1]) ? mag[0] : mag[1];
    max23   = (mag[2] > mag[3]) ? mag[2] : mag[3];
    largest = (max01 > max23) ? max01 : max23;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NW; i++) begin
        neg0_q[i]  <= data_i.sum[i][SumW-1];
        prod0_q[i] <= PW'(sabs[i][SumW-2:0]) * PW'(cfg_i.rpm_ratio);
      end
      mag1_q     <= mag;
      wheel1_q   <= wheel;
      largest1_q <= largest;
      scale1_q   <= largest > {1'b0, cfg_i.max_rpm};
      div_o.scale   <= scale1_q;
      div_o.divisor <= largest1_q;
      div_o.wheel   <= wheel1_q;
      for (int i = 0; i < NW; i++) begin
        div_o.dividend[i] <= DW'(mag1_q[i]) * DW'(cfg_i.max_rpm);
      end
    end
  end

  assign valid_o = v2_q;

endmodule

`default_nettype wire

[hw/rtl/mwsm_div.sv]
// Pipelined restoring divider for the rescale, one quotient bit per stage
// in four lanes, plus the result register. Depends on mwsm_pkg.
`default_nettype none

module mwsm_div (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire                              valid_i,
  input  mwsm_pkg::div_in_t                div_i,
  output logic                             out_valid_o,
  output logic [mwsm_pkg::NumWheels-1:0][mwsm_pkg::SpeedWidth-1:0] rpm_o
);

  localparam int unsigned NW = mwsm_pkg::NumWheels;
  localparam int unsigned SW = mwsm_pkg::SpeedWidth;
  localparam int unsigned NS = mwsm_pkg::DivSteps;

  logic [NS-1:0]                 v_q;
  logic [NS-1:0]                 scale_q;
  logic [NS-1:0][SW-1:0]         divisor_q;
  logic [NS-1:0][NW-1:0][SW-1:0] wheel_q;
  logic [NS-1:0][NW-1:0][SW-1:0] rem_q;
  logic [NS-1:0][NW-1:0][NS-1:0] sr_q;

  logic [NS-1:0][NW-1:0][SW-1:0] rem_in;
  logic [NS-1:0][NW-1:0][NS-1:0] sr_in;
  logic [NS-1:0][SW-1:0]         dvs_in;
  logic [NS-1:0][NW-1:0][SW-1:0] rem_nx;
  logic [NS-1:0][NW-1:0][NS-1:0] sr_nx;

  logic [NW-1:0][SW-1:0] res;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      for (int l = 0; l < NW; l++) begin
        if (s == 0) begin
          rem_in[s][l] = div_i.dividend[l][mwsm_pkg::DividendWidth-1:NS];
          sr_in[s][l]  = div_i.dividend[l][NS-1:0];
        end else begin
          rem_in[s][l] = rem_q[s-1][l];
          sr_in[s][l]  = sr_q[s-1][l];
        end
      end
      dvs_in[s] = (s == 0) ? div_i.divisor : divisor_q[s-1];
    end
  end

  // one restoring step per lane and stage; dividend bits shift out as
  // quotient bits shift in
  for (genvar s = 0; s < NS; s++) begin : g_stage
    for (genvar l = 0; l < NW; l++) begin : g_lane
      logic [SW:0] trial;
      logic        ge;
      assign trial = {rem_in[s][l], sr_in[s][l][NS-1]};
      assign ge    = trial >= {1'b0, dvs_in[s]};
      assign rem_nx[s][l] = ge ? SW'(trial - {1'b0, dvs_in[s]}) : trial[SW-1:0];
      assign sr_nx[s][l]  = {sr_in[s][l][NS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_o <= 1'b0;
    end else if (en_i) begin
      v_q         <= {v_q[NS-2:0], valid_i};
      out_valid_o <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NS; s++) begin
        rem_q[s]     <= rem_nx[s];
        sr_q[s]      <= sr_nx[s];
        divisor_q[s] <= dvs_in[s];
        if (s == 0) begin
          scale_q[s] <= div_i.scale;
          wheel_q[s] <= div_i.wheel;
        end else begin
          scale_q[s] <= scale_q[s-1];
          wheel_q[s] <= wheel_q[s-1];
        end
      end
      rpm_o <= res;
    end
  end

  always_comb begin
    for (int l = 0; l < NW; l++) begin
      if (!scale_q[NS-1]) begin
        res[l] = wheel_q[NS-1][l];
      end else if (wheel_q[NS-1][l][SW-1]) begin
        res[l] = SW'(-{1'b0, sr_q[NS-1][l]});
      end else begin
        res[l] = {1'b0, sr_q[NS-1][l]};
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mecanum_wheel_speed_mixer_unit.sv]
// Mecanum wheel speed mixer, top level: configuration registers, front,
// queue, back and divider. Depends on mwsm_pkg and the mwsm_* modules.
//
// Command channel (in_valid_i/in_ready_o): one beat carries speed_x_i,
// speed_y_i and speed_turn_i. Result channel (out_valid_o/out_ready_i):
// one beat carries the four wheel rpm setpoints for each command beat, in
// order. Configuration channel (cfg_valid_i/cfg_ready_o): index 0..5
// selects x_limit, y_limit, z_limit, rotate_ratio, rpm_ratio, max_rpm;
// other indexes are dropped. cfg_ready_o is always high; write only while
// no beats are in flight.
// Throughput: one beat per cycle while the result channel does not stall.
// With an empty queue a beat goes from command accept to result valid via
// the second front stage, the queue register, three back stages, the
// 15-stage rescale divider (one quotient bit per stage) and result register.
// Reset puts the registers at their documented defaults and empties the
// pipeline. When the receiver stalls, the back pipeline and result
// register hold, the two-entry queue fills and in_ready_o then drops.
`default_nettype none

module mecanum_wheel_speed_mixer_unit #(
  parameter int unsigned RATIO_FRAC_BITS = mwsm_pkg::RatioFracBits
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [mwsm_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  wire [mwsm_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire [mwsm_pkg::SpeedWidth-1:0]    speed_x_i,
  input  wire [mwsm_pkg::SpeedWidth-1:0]    speed_y_i,
  input  wire [mwsm_pkg::SpeedWidth-1:0]    speed_turn_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [mwsm_pkg::SpeedWidth-1:0]   rpm_right_front_o,
  output logic [mwsm_pkg::SpeedWidth-1:0]   rpm_left_front_o,
  output logic [mwsm_pkg::SpeedWidth-1:0]   rpm_left_rear_o,
  output logic [mwsm_pkg::SpeedWidth-1:0]   rpm_right_rear_o
);

  localparam int unsigned LW = mwsm_pkg::LimitWidth;
  localparam int unsigned RW = mwsm_pkg::RatioWidth;

  mwsm_pkg::cfg_t    cfg_q;
  mwsm_pkg::sums_t   front_entry, queue_data;
  mwsm_pkg::div_in_t div_in;
  logic push, full, queue_valid, back_valid, en;
  logic [mwsm_pkg::NumWheels-1:0][mwsm_pkg::SpeedWidth-1:0] rpm;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_limit      <= mwsm_pkg::XLimitReset;
      cfg_q.y_limit      <= mwsm_pkg::YLimitReset;
      cfg_q.z_limit      <= mwsm_pkg::ZLimitReset;
      cfg_q.rotate_ratio <= mwsm_pkg::RotateRatioReset;
      cfg_q.rpm_ratio    <= mwsm_pkg::RpmRatioReset;
      cfg_q.max_rpm      <= mwsm_pkg::MaxRpmReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mwsm_pkg::CfgXLimit:      cfg_q.x_limit      <= cfg_data_i[LW-1:0];
        mwsm_pkg::CfgYLimit:      cfg_q.y_limit      <= cfg_data_i[LW-1:0];
        mwsm_pkg::CfgZLimit:      cfg_q.z_limit      <= cfg_data_i[LW-1:0];
        mwsm_pkg::CfgRotateRatio: cfg_q.rotate_ratio <= cfg_data_i[RW-1:0];
        mwsm_pkg::CfgRpmRatio:    cfg_q.rpm_ratio    <= cfg_data_i[RW-1:0];
        mwsm_pkg::CfgMaxRpm:      cfg_q.max_rpm      <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // the whole back pipeline moves as one unless the result beat is stuck
  assign en = !out_valid_o || out_ready_i;

  mwsm_front #(
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .speed_x_i   (speed_x_i),
    .speed_y_i   (speed_y_i),
    .speed_turn_i(speed_turn_i),
    .push_o      (push),
    .full_i      (full),
    .entry_o     (front_entry)
  );

  mwsm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_entry),
    .full_o (full),
    .pop_i  (en),
    .valid_o(queue_valid),
    .data_o (queue_data)
  );

  mwsm_back #(
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .en_i   (en),
    .valid_i(queue_valid),
    .data_i (queue_data),
    .valid_o(back_valid),
    .div_o  (div_in)
  );

  mwsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (back_valid),
    .div_i      (div_in),
    .out_valid_o(out_valid_o),
    .rpm_o      (rpm)
  );

  assign rpm_right_front_o = rpm[0];
  assign rpm_left_front_o  = rpm[1];
  assign rpm_left_rear_o   = rpm[2];
  assign rpm_right_rear_o  = rpm[3];

endmodule

`default_nettype wire
